>>> sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // configuration register map
   localparam int CSR_INDEX_W = 8;
   localparam int CALIB_W     = 48;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_CALIB       = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CALIB_LOW  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CALIB_MID  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CALIB_HIGH = 8'd3;

   // field widths
   localparam int RAW_W  = 20;
   localparam int TEMP_W = 32;
   localparam int PRESS_W = 32;

   // arithmetic constants of the compensation formula
   localparam logic [31:0] TEMP_ROUND  = 32'd128;
   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_BASE  = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [63:0] X1_BIAS     = 64'h0000_8000_0000_0000;

   // restoring divider: one quotient bit per stage, divisor magnitude < 2^31
   localparam int DIV_STEPS = 64;
   localparam int DIV_REM_W = 31;

   // item data that rides along the divider
   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              neg;
      logic              zero;
   } bsc_side_type;

endpackage

>>> sv/bsc_req_if.sv
// ----------------------------------------------------------------------------
// bsc_req_if
// Raw sample pair channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic                         valid;
   logic                         ready;
   logic [bsc_pkg::RAW_W-1:0]    raw_temp;
   logic [bsc_pkg::RAW_W-1:0]    raw_press;

   modport source (output valid, output raw_temp, output raw_press, input ready);
   modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

>>> sv/bsc_rsp_if.sv
// ----------------------------------------------------------------------------
// bsc_rsp_if
// Compensated result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bsc_pkg::TEMP_W-1:0]   temp_centideg;
   logic [bsc_pkg::PRESS_W-1:0]         press_q24_8;
   logic                                press_valid;

   modport source (output valid, output temp_centideg, output press_q24_8,
                   output press_valid, input ready);
   modport sink   (input valid, input temp_centideg, input press_q24_8,
                   input press_valid, output ready);
endinterface

>>> sv/bsc_csr_if.sv
// ----------------------------------------------------------------------------
// bsc_csr_if
// Calibration register write channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bsc_pkg::CSR_INDEX_W-1:0]   index;
   logic [bsc_pkg::CALIB_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation of raw barometer samples.
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure pair per transaction and returns one
// result per transaction, in order: temperature in 0.01 degC and pressure in
// Q24.8 pascals, with press_valid low and pressure zero when the pressure
// divisor comes out zero. A new pair is taken every cycle; the pipeline has
// 11 front stages for the temperature and the pressure terms, 64 stages of
// the bit-per-stage divider and 6 back stages. The whole pipeline stalls
// only while a result waits at the output and the sink is not ready.
// Calibration registers are written through the csr channel, which is
// always ready; write them while no transaction is in flight.
module baro_sensor_compensation (
   input  logic     clock,
   input  logic     reset,
   bsc_csr_if.sink  csr_chan,
   bsc_req_if.sink  req_chan,
   bsc_rsp_if.source rsp_chan
);

   // ------------------------------------------------------------------
   // calibration registers
   logic [bsc_pkg::CALIB_W-1:0] temp_calib_ff;
   logic [bsc_pkg::CALIB_W-1:0] press_low_ff;
   logic [bsc_pkg::CALIB_W-1:0] press_mid_ff;
   logic [bsc_pkg::CALIB_W-1:0] press_high_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_high_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            bsc_pkg::REG_TEMP_CALIB:       temp_calib_ff <= csr_chan.data;
            bsc_pkg::REG_PRESS_CALIB_LOW:  press_low_ff  <= csr_chan.data;
            bsc_pkg::REG_PRESS_CALIB_MID:  press_mid_ff  <= csr_chan.data;
            bsc_pkg::REG_PRESS_CALIB_HIGH: press_high_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // calibration words, sign-extended where signed
   logic [15:0] t1;
   logic [31:0] t2x, t3x;
   logic [15:0] p1;
   logic [63:0] p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

   assign t1  = temp_calib_ff[15:0];
   assign t2x = {{16{temp_calib_ff[31]}}, temp_calib_ff[31:16]};
   assign t3x = {{16{temp_calib_ff[47]}}, temp_calib_ff[47:32]};
   assign p1  = press_low_ff[15:0];
   assign p2x = {{48{press_low_ff[31]}}, press_low_ff[31:16]};
   assign p3x = {{48{press_low_ff[47]}}, press_low_ff[47:32]};
   assign p4x = {{48{press_mid_ff[15]}}, press_mid_ff[15:0]};
   assign p5x = {{48{press_mid_ff[31]}}, press_mid_ff[31:16]};
   assign p6x = {{48{press_mid_ff[47]}}, press_mid_ff[47:32]};
   assign p7x = {{48{press_high_ff[15]}}, press_high_ff[15:0]};
   assign p8x = {{48{press_high_ff[31]}}, press_high_ff[31:16]};
   assign p9x = {{48{press_high_ff[47]}}, press_high_ff[47:32]};

   // ------------------------------------------------------------------
   // pipeline advance: everything moves unless the output is blocked
   logic rsp_valid_ff;
   logic adv;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   logic [10:0] f_vld_ff;
   logic [4:0]  b_vld_ff;
   logic        div_out_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff     <= '0;
         b_vld_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff     <= {f_vld_ff[9:0], req_chan.valid};
         b_vld_ff     <= {b_vld_ff[3:0], div_out_vld};
         rsp_valid_ff <= b_vld_ff[4];
      end
   end

   // ------------------------------------------------------------------
   // front stage registers
   logic [31:0] s1_m1_ff, s1_dd_ff;
   logic [19:0] s1_praw_ff, s2_praw_ff, s3_praw_ff, s4_praw_ff, s5_praw_ff;
   logic [19:0] s6_praw_ff, s7_praw_ff, s8_praw_ff;
   logic [31:0] s2_v1_ff, s2_v2m_ff;
   logic [31:0] s3_fine_ff;
   logic [31:0] s4_temp_ff, s5_temp_ff, s6_temp_ff, s7_temp_ff, s8_temp_ff;
   logic [31:0] s9_temp_ff, s10_temp_ff;
   logic [63:0] s4_x1_ff;
   logic [63:0] s5_ll_ff;
   logic [31:0] s5_hl_ff;
   logic [63:0] s5_x1p5_ff, s5_x1p2_ff, s6_x1p5_ff, s6_x1p2_ff, s7_x1p5_ff, s7_x1p2_ff;
   logic [63:0] s6_sq_ff;
   logic [63:0] s7_x2a_ff, s7_x3a_ff;
   logic [63:0] s8_x2_ff, s8_x1b_ff;
   logic [63:0] s9_sum_ff, s9_num_ff;
   logic [63:0] s10_prod_ff, s10_num_ff;
   logic [63:0] s11_mn_ff;
   logic [bsc_pkg::DIV_REM_W-1:0] s11_md_ff;
   bsc_pkg::bsc_side_type s11_side_ff;

   // next values
   logic [31:0] a1, d1, s1_m1_in, s1_dd_in;
   logic [31:0] dd_sh, s2_v1_in, s2_v2m_in;
   logic [31:0] s3_fine_in;
   logic [31:0] fine5, s4_temp_in;
   logic [63:0] s4_x1_in;
   logic [31:0] x1_lo, x1_hi, s5_hl_in;
   logic [63:0] s5_ll_in, s5_x1p5_in, s5_x1p2_in;
   logic [63:0] s6_sq_in;
   logic [63:0] s7_x2a_in, s7_x3a_in;
   logic [63:0] s8_x2_in, s8_x1b_in;
   logic [63:0] s9_sum_in, s9_num_in;
   logic [63:0] s10_prod_in, s10_num_in;
   logic [63:0] den, den_mag, s11_mn_in;
   bsc_pkg::bsc_side_type s11_side_in;

   always_comb begin
      // stage 1: offsets and first temperature products
      a1       = {15'b0, req_chan.raw_temp[19:3]} - {15'b0, t1, 1'b0};
      d1       = {16'b0, req_chan.raw_temp[19:4]} - {16'b0, t1};
      s1_m1_in = a1 * t2x;
      s1_dd_in = d1 * d1;
      // stage 2: scale and multiply by the third word
      s2_v1_in  = 32'($signed(s1_m1_ff) >>> 11);
      dd_sh     = 32'($signed(s1_dd_ff) >>> 12);
      s2_v2m_in = dd_sh * t3x;
      // stage 3: fine temperature
      s3_fine_in = s2_v1_ff + 32'($signed(s2_v2m_ff) >>> 14);
      // stage 4: centidegrees and pressure offset term
      fine5      = {s3_fine_ff[29:0], 2'b0} + s3_fine_ff;
      s4_temp_in = 32'($signed(fine5 + bsc_pkg::TEMP_ROUND) >>> 8);
      s4_x1_in   = {{32{s3_fine_ff[31]}}, s3_fine_ff} - bsc_pkg::FINE_OFFSET;
      // stage 5: square split in halves, linear terms
      x1_lo      = s4_x1_ff[31:0];
      x1_hi      = s4_x1_ff[63:32];
      s5_ll_in   = {32'b0, x1_lo} * {32'b0, x1_lo};
      s5_hl_in   = x1_hi * x1_lo;
      s5_x1p5_in = s4_x1_ff * p5x;
      s5_x1p2_in = s4_x1_ff * p2x;
      // stage 6: assemble the square modulo 2^64
      s6_sq_in = s5_ll_ff + {s5_hl_ff[30:0], 1'b0, 32'b0};
      // stage 7: square terms
      s7_x2a_in = s6_sq_ff * p6x;
      s7_x3a_in = s6_sq_ff * p3x;
      // stage 8: sum the terms of both intermediates
      s8_x2_in  = s7_x2a_ff + {s7_x1p5_ff[46:0], 17'b0} + {p4x[28:0], 35'b0};
      s8_x1b_in = 64'($signed(s7_x3a_ff) >>> 8) + {s7_x1p2_ff[51:0], 12'b0};
      // stage 9: bias the divisor term, form the numerator
      s9_sum_in = bsc_pkg::X1_BIAS + s8_x1b_ff;
      s9_num_in = ((bsc_pkg::PRESS_BASE - {44'b0, s8_praw_ff}) << 31) - s8_x2_ff;
      // stage 10: divisor product and numerator scale
      s10_prod_in = s9_sum_ff * {48'b0, p1};
      s10_num_in  = s9_num_ff * bsc_pkg::PRESS_SCALE;
      // stage 11: magnitudes and signs for the divider
      den              = 64'($signed(s10_prod_ff) >>> 33);
      den_mag          = den[63] ? (64'd0 - den) : den;
      s11_mn_in        = s10_num_ff[63] ? (64'd0 - s10_num_ff) : s10_num_ff;
      s11_side_in.temp = s10_temp_ff;
      s11_side_in.neg  = s10_num_ff[63] ^ den[63];
      s11_side_in.zero = (den == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_m1_ff    <= s1_m1_in;
         s1_dd_ff    <= s1_dd_in;
         s1_praw_ff  <= req_chan.raw_press;
         s2_v1_ff    <= s2_v1_in;
         s2_v2m_ff   <= s2_v2m_in;
         s2_praw_ff  <= s1_praw_ff;
         s3_fine_ff  <= s3_fine_in;
         s3_praw_ff  <= s2_praw_ff;
         s4_temp_ff  <= s4_temp_in;
         s4_x1_ff    <= s4_x1_in;
         s4_praw_ff  <= s3_praw_ff;
         s5_ll_ff    <= s5_ll_in;
         s5_hl_ff    <= s5_hl_in;
         s5_x1p5_ff  <= s5_x1p5_in;
         s5_x1p2_ff  <= s5_x1p2_in;
         s5_temp_ff  <= s4_temp_ff;
         s5_praw_ff  <= s4_praw_ff;
         s6_sq_ff    <= s6_sq_in;
         s6_x1p5_ff  <= s5_x1p5_ff;
         s6_x1p2_ff  <= s5_x1p2_ff;
         s6_temp_ff  <= s5_temp_ff;
         s6_praw_ff  <= s5_praw_ff;
         s7_x2a_ff   <= s7_x2a_in;
         s7_x3a_ff   <= s7_x3a_in;
         s7_x1p5_ff  <= s6_x1p5_ff;
         s7_x1p2_ff  <= s6_x1p2_ff;
         s7_temp_ff  <= s6_temp_ff;
         s7_praw_ff  <= s6_praw_ff;
         s8_x2_ff    <= s8_x2_in;
         s8_x1b_ff   <= s8_x1b_in;
         s8_temp_ff  <= s7_temp_ff;
         s8_praw_ff  <= s7_praw_ff;
         s9_sum_ff   <= s9_sum_in;
         s9_num_ff   <= s9_num_in;
         s9_temp_ff  <= s8_temp_ff;
         s10_prod_ff <= s10_prod_in;
         s10_num_ff  <= s10_num_in;
         s10_temp_ff <= s9_temp_ff;
         s11_mn_ff   <= s11_mn_in;
         s11_md_ff   <= den_mag[bsc_pkg::DIV_REM_W-1:0];
         s11_side_ff <= s11_side_in;
      end
   end

   // ------------------------------------------------------------------
   // quotient magnitude
   logic [63:0]           div_quot;
   bsc_pkg::bsc_side_type div_side;

   bsc_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_vld      (f_vld_ff[10]),
      .in_dividend (s11_mn_ff),
      .in_divisor  (s11_md_ff),
      .in_side     (s11_side_ff),
      .out_vld     (div_out_vld),
      .out_quot    (div_quot),
      .out_side    (div_side)
   );

   // ------------------------------------------------------------------
   // back stage registers
   logic [63:0] q1_p_ff, q2_p_ff, q3_p_ff, q4_p_ff;
   logic [63:0] q2_ph_ff, q2_y2m_ff, q2_a_ff;
   logic [63:0] q3_ll_ff, q3_y2m_ff, q4_y2m_ff;
   logic [31:0] q3_lh_ff, q3_hl_ff;
   logic [63:0] q4_y1m_ff;
   logic [63:0] q5_s_ff;
   bsc_pkg::bsc_side_type q1_side_ff, q2_side_ff, q3_side_ff, q4_side_ff, q5_side_ff;
   logic [31:0] rsp_temp_ff, rsp_press_ff;
   logic        rsp_pvalid_ff;

   logic [63:0] q1_p_in, q2_ph_in, q2_y2m_in, q2_a_in;
   logic [63:0] q3_ll_in;
   logic [31:0] q3_lh_in, q3_hl_in;
   logic [63:0] q4_y1m_in, q5_s_in, press_full;
   logic [31:0] rsp_press_in;

   always_comb begin
      // q1: apply the quotient sign
      q1_p_in = div_side.neg ? (64'd0 - div_quot) : div_quot;
      // q2: scaled pressure and first products
      q2_ph_in  = 64'($signed(q1_p_ff) >>> 13);
      q2_y2m_in = q1_p_ff * p8x;
      q2_a_in   = p9x * q2_ph_in;
      // q3: partial products of the cubic term, modulo 2^64
      q3_ll_in = {32'b0, q2_a_ff[31:0]} * {32'b0, q2_ph_ff[31:0]};
      q3_lh_in = q2_a_ff[31:0] * q2_ph_ff[63:32];
      q3_hl_in = q2_a_ff[63:32] * q2_ph_ff[31:0];
      // q4: assemble the cubic term
      q4_y1m_in = q3_ll_ff + {q3_lh_ff + q3_hl_ff, 32'b0};
      // q5: sum of correction terms
      q5_s_in = q4_p_ff + 64'($signed(q4_y1m_ff) >>> 25)
              + 64'($signed(q4_y2m_ff) >>> 19);
      // output: final offset, zero on a zero divisor
      press_full   = 64'($signed(q5_s_ff) >>> 8) + {p7x[59:0], 4'b0};
      rsp_press_in = q5_side_ff.zero ? 32'd0 : press_full[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_p_ff       <= q1_p_in;
         q1_side_ff    <= div_side;
         q2_ph_ff      <= q2_ph_in;
         q2_y2m_ff     <= q2_y2m_in;
         q2_a_ff       <= q2_a_in;
         q2_p_ff       <= q1_p_ff;
         q2_side_ff    <= q1_side_ff;
         q3_ll_ff      <= q3_ll_in;
         q3_lh_ff      <= q3_lh_in;
         q3_hl_ff      <= q3_hl_in;
         q3_y2m_ff     <= q2_y2m_ff;
         q3_p_ff       <= q2_p_ff;
         q3_side_ff    <= q2_side_ff;
         q4_y1m_ff     <= q4_y1m_in;
         q4_y2m_ff     <= q3_y2m_ff;
         q4_p_ff       <= q3_p_ff;
         q4_side_ff    <= q3_side_ff;
         q5_s_ff       <= q5_s_in;
         q5_side_ff    <= q4_side_ff;
         rsp_temp_ff   <= q5_side_ff.temp;
         rsp_press_ff  <= rsp_press_in;
         rsp_pvalid_ff <= !q5_side_ff.zero;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.temp_centideg = rsp_temp_ff;
   assign rsp_chan.press_q24_8   = rsp_press_ff;
   assign rsp_chan.press_valid   = rsp_pvalid_ff;

   // ------------------------------------------------------------------
   // checks

   // an invalid pressure always reads as zero
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pvalid_ff) |-> (rsp_press_ff == 32'd0))
      else $error("invalid pressure not zero");

   // a stall freezes the front valid chain
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(f_vld_ff))
      else $error("front pipeline moved during stall");

   // an accepted transaction lands in the first stage
   a_accept_enter: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> f_vld_ff[0])
      else $error("accepted transaction lost at entry");

endmodule

>>> sv/bsc_divider.sv
// ----------------------------------------------------------------------------
// bsc_divider
// Pipelined restoring divider, unsigned 64-bit dividend by 31-bit divisor,
// one quotient bit per stage, stalls with the rest of the pipeline.
// ----------------------------------------------------------------------------
module bsc_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_vld,
   input  logic [63:0]                         in_dividend,
   input  logic [bsc_pkg::DIV_REM_W-1:0]       in_divisor,
   input  bsc_pkg::bsc_side_type               in_side,
   output logic                                out_vld,
   output logic [63:0]                         out_quot,
   output bsc_pkg::bsc_side_type               out_side
);

   localparam int Steps = bsc_pkg::DIV_STEPS;
   localparam int RemW  = bsc_pkg::DIV_REM_W;

   logic                  vld_ff  [Steps];
   logic [63:0]           dq_ff   [Steps];
   logic [RemW-1:0]       rem_ff  [Steps];
   logic [RemW-1:0]       md_ff   [Steps];
   bsc_pkg::bsc_side_type side_ff [Steps];

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic                  src_vld;
      logic [63:0]           src_dq;
      logic [RemW-1:0]       src_rem;
      logic [RemW-1:0]       src_md;
      bsc_pkg::bsc_side_type src_side;
      logic [RemW:0]         trial;
      logic [RemW:0]         diff;
      logic                  take;
      logic [63:0]           dq_in;
      logic [RemW-1:0]       rem_in;

      // source: ports for the first step, previous stage otherwise
      if (k == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_dq   = in_dividend;
         assign src_rem  = '0;
         assign src_md   = in_divisor;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_dq   = dq_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_md   = md_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      // shift in next dividend bit, subtract divisor when it fits
      assign trial  = {src_rem, src_dq[63]};
      assign diff   = trial - {1'b0, src_md};
      assign take   = (trial >= {1'b0, src_md});
      assign dq_in  = {src_dq[62:0], take};
      assign rem_in = take ? diff[RemW-1:0] : trial[RemW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_vld;
         end
         if (adv) begin
            dq_ff[k]   <= dq_in;
            rem_ff[k]  <= rem_in;
            md_ff[k]   <= src_md;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_vld  = vld_ff[Steps-1];
   assign out_quot = dq_ff[Steps-1];
   assign out_side = side_ff[Steps-1];

endmodule
